FILE: design/ccob_pkg.sv
// shared types and constants for the constant color over blend unit
package ccob_pkg;

  // configuration port geometry
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_BLEND_RED   = 3'd0;
  localparam logic [2:0] REG_BLEND_GREEN = 3'd1;
  localparam logic [2:0] REG_BLEND_BLUE  = 3'd2;
  localparam logic [2:0] REG_BLEND_ALPHA = 3'd3;
  localparam logic [2:0] REG_PREMULT     = 3'd4;

  // blend arithmetic constants
  localparam logic [7:0]  ALPHA_ZERO = 8'h00;
  localparam logic [7:0]  ALPHA_FULL = 8'hFF;
  localparam logic [16:0] ROUND_BIAS = 17'd127;
  localparam logic [16:0] SAT_LIMIT  = 17'd65280;  // 256 * 255

  typedef struct packed {
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
    logic [7:0] pixel_alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
  } result_t;

  typedef struct packed {
    logic [7:0] blend_red;
    logic [7:0] blend_green;
    logic [7:0] blend_blue;
    logic [7:0] blend_alpha;
    logic       premultiplied_mode;
  } cfg_t;

endpackage

FILE: design/ccob_cfg_regs.sv
// apb register file holding the overlay color, opacity and blend mode
module ccob_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ccob_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ccob_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ccob_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output ccob_pkg::cfg_t                   cfg
);
  import ccob_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_BLEND_RED:   cfg_nxt.blend_red          = pwdata[7:0];
        REG_BLEND_GREEN: cfg_nxt.blend_green        = pwdata[7:0];
        REG_BLEND_BLUE:  cfg_nxt.blend_blue         = pwdata[7:0];
        REG_BLEND_ALPHA: cfg_nxt.blend_alpha        = pwdata[7:0];
        REG_PREMULT:     cfg_nxt.premultiplied_mode = pwdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLEND_RED:   prdata = {24'd0, cfg_r.blend_red};
      REG_BLEND_GREEN: prdata = {24'd0, cfg_r.blend_green};
      REG_BLEND_BLUE:  prdata = {24'd0, cfg_r.blend_blue};
      REG_BLEND_ALPHA: prdata = {24'd0, cfg_r.blend_alpha};
      REG_PREMULT:     prdata = {31'd0, cfg_r.premultiplied_mode};
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: design/ccob_channel_mix.sv
// one color channel blend: two 8x8 products, rounding, divide by 255, saturate
module ccob_channel_mix (
  input  logic [7:0] color,
  input  logic [7:0] pixel,
  input  logic [7:0] alpha,
  input  logic       premult,
  output logic [7:0] mixed
);
  import ccob_pkg::*;

  logic [7:0]  inv_alpha;
  logic [15:0] color_term;
  logic [15:0] pixel_term;
  logic [16:0] sum;
  logic [15:0] sum_lo;
  logic [15:0] div_acc;
  logic        sat;

  assign inv_alpha = ALPHA_FULL - alpha;

  // premultiplied color weighs by 255, straight color by alpha
  assign color_term = premult ? ({color, 8'h00} - {8'h00, color})
                              : (16'(color) * 16'(alpha));
  assign pixel_term = 16'(pixel) * 16'(inv_alpha);
  assign sum        = {1'b0, color_term} + {1'b0, pixel_term} + ROUND_BIAS;

  // quotient would exceed 255 exactly when sum reaches 256*255
  assign sat     = (sum >= SAT_LIMIT);
  assign sum_lo  = sum[15:0];
  // exact x/255 for x below 256*255
  assign div_acc = sum_lo + 16'd1 + {8'h00, sum_lo[15:8]};

  always_comb begin
    if (alpha == ALPHA_ZERO) begin
      mixed = pixel;
    end else if (alpha == ALPHA_FULL) begin
      mixed = color;
    end else if (sat) begin
      mixed = 8'hFF;
    end else begin
      mixed = div_acc[15:8];
    end
  end

endmodule

FILE: design/constant_color_over_blend_unit.sv
// top level: constant color over blend with apb configuration
//
//  channel   ports                                   handshake
//  input     start, busy, in_pixel                   start & !busy, busy stays low
//  result    out_valid, out_result                   one-cycle strobe, no backpressure
//  config    psel penable pwrite paddr pwdata        write at psel&penable&pwrite&pready
//            prdata pready                           pready always high
//
// one pixel transaction is accepted every cycle; its result passes through the input
// register, then the channel blend logic, then the result register, whose output drives
// the result strobe
// rst_n is synchronous; it clears the valid flags and all config registers
// the receiver cannot stall, so the pipeline never holds and busy is never raised
// config must be written only while no pixel is in flight; the block does not enforce this
module constant_color_over_blend_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel input
  input  logic                             start,
  output logic                             busy,
  input  ccob_pkg::pixel_t                 in_pixel,
  // blended result
  output logic                             out_valid,
  output ccob_pkg::result_t                out_result,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ccob_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ccob_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ccob_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import ccob_pkg::*;

  cfg_t    cfg;
  pixel_t  pix_r;
  logic    pix_vld_r;
  result_t res_r;
  result_t res_nxt;
  logic    res_vld_r;
  logic    in_take;

  // no backpressure anywhere, so the unit is always ready
  assign busy    = 1'b0;
  assign in_take = start & ~busy;

  ccob_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_vld_r <= 1'b0;
    end else begin
      pix_vld_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pix_r <= in_pixel;
    end
  end

  // per-channel blend logic
  ccob_channel_mix u_mix_blue (
    .color   (cfg.blend_blue),
    .pixel   (pix_r.pixel_blue),
    .alpha   (cfg.blend_alpha),
    .premult (cfg.premultiplied_mode),
    .mixed   (res_nxt.out_blue)
  );

  ccob_channel_mix u_mix_green (
    .color   (cfg.blend_green),
    .pixel   (pix_r.pixel_green),
    .alpha   (cfg.blend_alpha),
    .premult (cfg.premultiplied_mode),
    .mixed   (res_nxt.out_green)
  );

  ccob_channel_mix u_mix_red (
    .color   (cfg.blend_red),
    .pixel   (pix_r.pixel_red),
    .alpha   (cfg.blend_alpha),
    .premult (cfg.premultiplied_mode),
    .mixed   (res_nxt.out_red)
  );

  // alpha byte of the pixel passes through untouched
  assign res_nxt.out_alpha = pix_r.pixel_alpha;

  // result register stage, strobed for one cycle per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= pix_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid  = res_vld_r;
  assign out_result = res_r;

endmodule

FILE: test/tb_constant_color_over_blend_unit.sv
// testbench for the constant color over blend unit: apb setup, pixel stream, result checks
`timescale 1ns / 100ps

module tb_constant_color_over_blend_unit;
  import ccob_pkg::*;

  // register slots past the last real register; writes there must be ignored
  localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] REG_UNUSED_LAST  = 3'd7;

  localparam int RESET_CYCLES  = 6;
  localparam int DRAIN_CYCLES  = 4;    // extra wait after the last expected result, as margin
  localparam int STALL_LIMIT   = 200;  // longest correct quiet stretch is well under this
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_PIXELS  = 100;

  // expected-pixel store with its own copy of the overlay settings
  class blend_checker;
    cfg_t    overlay;
    result_t blended_q[$];
    int      errors;

    function new();
      overlay = '0;
      errors  = 0;
    endfunction

    // mirror one register write, with the same masking as the hardware
    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_BLEND_RED:   overlay.blend_red          = data[7:0];
        REG_BLEND_GREEN: overlay.blend_green        = data[7:0];
        REG_BLEND_BLUE:  overlay.blend_blue         = data[7:0];
        REG_BLEND_ALPHA: overlay.blend_alpha        = data[7:0];
        REG_PREMULT:     overlay.premultiplied_mode = data[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] mix_channel(logic [7:0] color, logic [7:0] pix);
      int unsigned a;
      int unsigned sum;
      a = 32'(overlay.blend_alpha);
      if (overlay.blend_alpha == ALPHA_ZERO) return pix;
      if (overlay.blend_alpha == ALPHA_FULL) return color;
      if (overlay.premultiplied_mode) begin
        sum = (int'(color) * 255 + (255 - a) * int'(pix) + 127) / 255;
        return (sum > 255) ? 8'hFF : sum[7:0];
      end
      sum = (int'(color) * a + (255 - a) * int'(pix) + 127) / 255;
      return sum[7:0];
    endfunction

    function void note_pixel(pixel_t px);
      result_t r;
      r.out_blue  = mix_channel(overlay.blend_blue, px.pixel_blue);
      r.out_green = mix_channel(overlay.blend_green, px.pixel_green);
      r.out_red   = mix_channel(overlay.blend_red, px.pixel_red);
      r.out_alpha = px.pixel_alpha;
      blended_q.push_back(r);
    endfunction

    function void compare_byte(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (blended_q.size() == 0) begin
        $display("%0t: result %h with none expected", $time, got);
        errors++;
        return;
      end
      want = blended_q.pop_front();
      compare_byte("out_blue", want.out_blue, got.out_blue);
      compare_byte("out_green", want.out_green, got.out_green);
      compare_byte("out_red", want.out_red, got.out_red);
      compare_byte("out_alpha", want.out_alpha, got.out_alpha);
    endfunction

    function int pending();
      return blended_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  pixel_t      in_pixel;
  logic        out_valid;
  result_t     out_result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic        pready;

  blend_checker sb = new();
  bit           no_gaps;     // set for back-to-back stretches
  int           stall_cycles;

  // fixed corner pixels for the directed part
  pixel_t corner_pixels [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5AA5_3CC3, 32'h0180_FE7F};

  constant_color_over_blend_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_pixel   (in_pixel),
    .out_valid  (out_valid),
    .out_result (out_result),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: every accepted pixel gets a prediction, every strobe is checked;
  // sampled at the rising edge, before any register in the block updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_pixel(in_pixel);
      if (out_valid) sb.check_result(out_result);
    end
  end

  // watchdog: counts edges with no pixel, result or register write
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one apb write: setup phase, then access phase until pready
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // full overlay setup; unused upper data bits carry noise that must be masked
  task automatic set_overlay(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic [7:0] alpha,
                             input logic mode);
    cfg_write(REG_BLEND_RED,   {24'($urandom()), red});
    cfg_write(REG_BLEND_GREEN, {24'($urandom()), green});
    cfg_write(REG_BLEND_BLUE,  {24'($urandom()), blue});
    cfg_write(REG_BLEND_ALPHA, {24'($urandom()), alpha});
    cfg_write(REG_PREMULT,     {31'($urandom()), mode});
  endtask

  // one pixel transaction, with an optional idle gap in front
  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      start    <= 1'b0;
      in_pixel <= $urandom();
    end
    @(negedge clk);
    start    <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (busy);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // extremes show up far more often than a flat draw would give them
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 6))
      0: return ALPHA_ZERO;
      1: return ALPHA_FULL;
      2: return 8'h01;
      3: return 8'hFE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t pick_pixel();
    pixel_t px;
    if ($urandom_range(0, 1)) begin
      px = $urandom();
    end else begin
      px = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    end
    return px;
  endfunction

  initial begin
    int k;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_pixel = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    no_gaps  = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: opacity zero, pixels pass through
    foreach (corner_pixels[j]) send_pixel(corner_pixels[j]);
    drain();

    // opacity full: color bytes become the overlay color
    set_overlay(8'hFF, 8'h00, 8'h80, ALPHA_FULL, 1'b0);
    foreach (corner_pixels[j]) send_pixel(corner_pixels[j]);
    drain();

    // half opacity, straight blend with rounding
    set_overlay(8'hFF, 8'h00, 8'h7F, 8'h80, 1'b0);
    foreach (corner_pixels[j]) send_pixel(corner_pixels[j]);
    drain();

    // premultiplied, bright overlay over bright pixel saturates
    set_overlay(8'hFF, 8'hFF, 8'h40, 8'h80, 1'b1);
    foreach (corner_pixels[j]) send_pixel(corner_pixels[j]);
    drain();

    // opacity one step off each end, premultiplied; also a write to an unused slot
    cfg_write(REG_UNUSED_FIRST, 32'hFFFF_FFFF);
    set_overlay(8'h00, 8'hFF, 8'hFF, 8'h01, 1'b1);
    send_pixel(corner_pixels[1]);
    send_pixel(corner_pixels[2]);
    drain();
    set_overlay(8'hFF, 8'h00, 8'hFF, 8'hFE, 1'b1);
    send_pixel(corner_pixels[0]);
    send_pixel(corner_pixels[1]);
    drain();

    // random phases: new overlay each time, some back to back, some with gaps
    for (k = 0; k < RANDOM_PHASES; k++) begin
      if ($urandom_range(0, 2) == 0) begin
        cfg_write(3'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), $urandom());
      end
      set_overlay(pick_byte(), pick_byte(), pick_byte(), pick_alpha(),
                  1'($urandom_range(0, 1)));
      no_gaps = ($urandom_range(0, 2) == 0);
      repeat (PHASE_PIXELS) begin
        // occasional switch between bursts and gapped traffic inside a phase
        if ($urandom_range(0, 31) == 0) no_gaps = !no_gaps;
        send_pixel(pick_pixel());
      end
      drain();
    end

    if (sb.pending() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
